>>> rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Widths, codes and shared types of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int FRAMES_MAX  = 64;

    localparam int TIME_W      = 16;
    localparam int COUNT_W     = 7;
    localparam int MODE_W      = 2;
    localparam int WIDTH_W     = 11;
    localparam int KIND_W      = 2;
    localparam int DELTA_W     = 16;
    localparam int ELAPSED_W   = 32;
    localparam int STEP_W      = 7;
    localparam int INDEX_W     = 6;
    localparam int SRC_X_W     = 16;
    localparam int PROD_W      = WIDTH_W + INDEX_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] FRAMES_MAX_COUNT = COUNT_W'(FRAMES_MAX);

    localparam logic [TIME_W-1:0]  RESET_FRAME_PERIOD = TIME_W'(100);
    localparam logic [COUNT_W-1:0] RESET_FRAME_COUNT  = COUNT_W'(1);
    localparam logic [WIDTH_W-1:0] RESET_FRAME_WIDTH  = WIDTH_W'(16);

    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_RESTART
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_PERIOD,
        REG_FRAME_COUNT,
        REG_ANIM_MODE,
        REG_FRAME_WIDTH,
        REG_START_REVERSE,
        REG_START_RUNNING
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  frame_period;
        logic [COUNT_W-1:0] frame_count;
        logic [MODE_W-1:0]  anim_mode;
        logic [WIDTH_W-1:0] frame_width;
        logic               start_reverse;
        logic               start_running;
    } sfs_cfg_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic [STEP_W-1:0]    step_count;
        logic                 is_running;
        logic                 is_reverse;
        logic [INDEX_W-1:0]   shown_index;
    } sfs_state_t;

    typedef struct packed {
        logic [INDEX_W-1:0] frame_index;
        logic [SRC_X_W-1:0] src_x;
        logic               running;
        logic               reversed;
    } sfs_result_t;

endpackage

>>> rtl/sfs_if.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface sfs_item_if;
    logic                       valid;
    logic                       ready;
    logic [sfs_pkg::KIND_W-1:0]  kind;
    logic [sfs_pkg::DELTA_W-1:0] delta;

    modport source (output valid, output kind, output delta, input ready);
    modport sink   (input valid, input kind, input delta, output ready);
endinterface

interface sfs_result_if;
    logic                        valid;
    logic                        ready;
    logic [sfs_pkg::INDEX_W-1:0] frame_index;
    logic [sfs_pkg::SRC_X_W-1:0] src_x;
    logic                        running;
    logic                        reversed;

    modport source (output valid, output frame_index, output src_x, output running,
                    output reversed, input ready);
    modport sink   (input valid, input frame_index, input src_x, input running,
                    input reversed, output ready);
endinterface

interface sfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sfs_pkg::CFG_INDEX_W-1:0] index;
    logic [sfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sfs_step.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer step logic
// Next animation state and shown-frame result for one tick or event.
// ----------------------------------------------------------------------------
module sfs_step
(
    input  sfs_pkg::sfs_cfg_t              cfg_regs,
    input  sfs_pkg::sfs_state_t            state,
    input  logic [sfs_pkg::KIND_W-1:0]     kind,
    input  logic [sfs_pkg::DELTA_W-1:0]    delta,
    output sfs_pkg::sfs_state_t            state_next,
    output sfs_pkg::sfs_result_t           result
);

    logic [sfs_pkg::COUNT_W-1:0]   used_count;
    logic [sfs_pkg::ELAPSED_W:0]   sum;
    logic [sfs_pkg::ELAPSED_W-1:0] acc;
    logic                          over;
    logic [sfs_pkg::STEP_W-1:0]    step_inc;
    logic [sfs_pkg::STEP_W-1:0]    adv_step;
    logic                          adv_running;
    logic                          adv_reverse;
    logic [sfs_pkg::COUNT_W-1:0]   mirror;
    logic [sfs_pkg::PROD_W-1:0]    prod;

    always_comb
    begin
        if (cfg_regs.frame_count == '0)
        begin
            used_count = sfs_pkg::COUNT_W'(1);
        end
        else if (cfg_regs.frame_count > sfs_pkg::FRAMES_MAX_COUNT)
        begin
            used_count = sfs_pkg::FRAMES_MAX_COUNT;
        end
        else
        begin
            used_count = cfg_regs.frame_count;
        end
    end

    assign sum  = {1'b0, state.elapsed} + (sfs_pkg::ELAPSED_W + 1)'(delta);
    assign acc  = sum[sfs_pkg::ELAPSED_W] ? '1 : sum[sfs_pkg::ELAPSED_W-1:0];
    assign over = acc > sfs_pkg::ELAPSED_W'(cfg_regs.frame_period);
    assign step_inc = state.step_count + sfs_pkg::STEP_W'(1);

    always_comb
    begin
        adv_step    = step_inc;
        adv_running = state.is_running;
        adv_reverse = state.is_reverse;
        if (sfs_pkg::COUNT_W'(step_inc) >= used_count)
        begin
            case (cfg_regs.anim_mode)
                sfs_pkg::MODE_SINGLE:
                begin
                    adv_step    = sfs_pkg::STEP_W'(used_count - sfs_pkg::COUNT_W'(1));
                    adv_running = 1'b0;
                end
                sfs_pkg::MODE_BOUNCE:
                begin
                    adv_step    = (used_count >= sfs_pkg::COUNT_W'(2)) ?
                                  sfs_pkg::STEP_W'(1) : '0;
                    adv_reverse = !state.is_reverse;
                end
                default:
                begin
                    adv_step = '0;
                end
            endcase
        end
    end

    assign mirror = used_count - sfs_pkg::COUNT_W'(1) - sfs_pkg::COUNT_W'(adv_step);

    always_comb
    begin
        state_next = state;
        unique case (sfs_pkg::kind_t'(kind))
            sfs_pkg::KIND_TICK:
            begin
                if (state.is_running)
                begin
                    state_next.elapsed = acc;
                    if (over)
                    begin
                        state_next.elapsed     = acc -
                                                 sfs_pkg::ELAPSED_W'(cfg_regs.frame_period);
                        state_next.step_count  = adv_step;
                        state_next.is_running  = adv_running;
                        state_next.is_reverse  = adv_reverse;
                        state_next.shown_index = adv_reverse ?
                                                 mirror[sfs_pkg::INDEX_W-1:0] :
                                                 adv_step[sfs_pkg::INDEX_W-1:0];
                    end
                end
            end
            sfs_pkg::KIND_START:
            begin
                state_next.is_running = 1'b1;
            end
            sfs_pkg::KIND_STOP:
            begin
                state_next.is_running = 1'b0;
            end
            sfs_pkg::KIND_RESTART:
            begin
                state_next.elapsed     = '0;
                state_next.step_count  = '0;
                state_next.shown_index = '0;
                state_next.is_running  = cfg_regs.start_running;
                state_next.is_reverse  = cfg_regs.start_reverse;
            end
        endcase
    end

    assign prod = sfs_pkg::PROD_W'(cfg_regs.frame_width) * sfs_pkg::PROD_W'(state_next.shown_index);

    assign result.frame_index = state_next.shown_index;
    assign result.src_x       = (prod > sfs_pkg::PROD_W'({sfs_pkg::SRC_X_W{1'b1}})) ?
                                '1 : prod[sfs_pkg::SRC_X_W-1:0];
    assign result.running     = state_next.is_running;
    assign result.reversed    = state_next.is_reverse;

endmodule

>>> rtl/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps a sprite strip animation on time ticks and control events and
// reports the shown frame and its source x for every item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake    Payload
// item      in         valid/ready  kind, delta
// result    out        valid/ready  frame_index, src_x, running, reversed
// cfg       in         valid/ready  index, data (always ready)
//
// Each item passes through the input register and then the result register,
// where its result is presented until it is taken.
// One item is accepted per cycle while results are taken; the step logic
// between the two registers is combinational. When the result is not taken,
// the result register holds, the input register still takes one transfer
// if it is empty, and input ready drops once it is full. Reset loads the
// register defaults and clears the state.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
(
    input  logic            clk,
    input  logic            rst_n,
    sfs_item_if.sink        item,
    sfs_result_if.source    result,
    sfs_cfg_if.sink         cfg
);

    sfs_pkg::sfs_cfg_t            cfg_reg;
    sfs_pkg::sfs_state_t          state_reg;
    sfs_pkg::sfs_state_t          state_next;
    sfs_pkg::sfs_result_t         step_result;
    sfs_pkg::sfs_result_t         out_reg;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [sfs_pkg::KIND_W-1:0]   s1_kind_reg;
    logic [sfs_pkg::DELTA_W-1:0]  s1_delta_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_load;
    logic                         s1_move;
    logic                         item_xfer;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period  <= sfs_pkg::RESET_FRAME_PERIOD;
            cfg_reg.frame_count   <= sfs_pkg::RESET_FRAME_COUNT;
            cfg_reg.anim_mode     <= sfs_pkg::MODE_LOOP;
            cfg_reg.frame_width   <= sfs_pkg::RESET_FRAME_WIDTH;
            cfg_reg.start_reverse <= 1'b0;
            cfg_reg.start_running <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (sfs_pkg::cfg_reg_t'(cfg.index))
                sfs_pkg::REG_FRAME_PERIOD:
                    cfg_reg.frame_period  <= cfg.data[sfs_pkg::TIME_W-1:0];
                sfs_pkg::REG_FRAME_COUNT:
                    cfg_reg.frame_count   <= cfg.data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::REG_ANIM_MODE:
                    cfg_reg.anim_mode     <= cfg.data[sfs_pkg::MODE_W-1:0];
                sfs_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width   <= cfg.data[sfs_pkg::WIDTH_W-1:0];
                sfs_pkg::REG_START_REVERSE:
                    cfg_reg.start_reverse <= cfg.data[0];
                sfs_pkg::REG_START_RUNNING:
                    cfg_reg.start_running <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_load   = !out_valid_reg || result.ready;
    assign s1_move    = s1_valid_reg && out_load;
    assign item.ready = !s1_valid_reg || s1_move;
    assign item_xfer  = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    sfs_step u_step
    (
        .cfg_regs   (cfg_reg),
        .state      (state_reg),
        .kind       (s1_kind_reg),
        .delta      (s1_delta_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_kind_reg  <= item.kind;
            s1_delta_reg <= item.delta;
        end
        if (s1_move)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.frame_index = out_reg.frame_index;
    assign result.src_x       = out_reg.src_x;
    assign result.running     = out_reg.running;
    assign result.reversed    = out_reg.reversed;

    a_item_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> s1_valid_reg)
        else $error("accepted item did not reach the input register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(state_reg))
        else $error("animation state changed without an item");

    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_kind_reg == sfs_pkg::KIND_RESTART) |=>
        (state_reg.elapsed == '0 && state_reg.step_count == '0 &&
         state_reg.shown_index == '0))
        else $error("restart did not clear the animation state");

    a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (result.valid && result.running == state_reg.is_running &&
                     result.frame_index == state_reg.shown_index))
        else $error("result does not match the updated state");

endmodule
